FILE: src/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Types and codes shared by the ordered list store controller and datapath.
// ----------------------------------------------------------------------------
package ols_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_DRAIN,
    S_FINAL,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                command;
    logic [6:0]         position;
    logic signed [31:0] value;
  } ols_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         element_count;
    logic [6:0]         capacity;
  } ols_out_t;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       step;
    logic       rd_issue;
    logic       finish;
    logic       latch;
    logic [1:0] status;
  } ols_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic full;
    logic need_shift;
    logic last;
  } ols_stat_t;

endpackage

FILE: src/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ols_ctrl
// Sequencer that checks each request, runs the entry shift and reports.
// ----------------------------------------------------------------------------
module ols_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ols_pkg::ols_stat_t stat,
  output logic              busy,
  output ols_pkg::ols_cmd_t  cmd
);
  import ols_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_DONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.latch  = 1'b1;
          cmd.status = ST_BADPOS;
          state_next = S_IDLE;
        end else begin
          case (stat.op)
            OP_READ: begin
              cmd.rd_issue = 1'b1;
              state_next   = S_READ;
            end
            OP_ERASE: begin
              cmd.setup  = 1'b1;
              state_next = stat.need_shift ? S_SHIFT : S_FINAL;
            end
            default: begin
              if (stat.full) begin
                cmd.latch  = 1'b1;
                cmd.status = ST_FULL;
                state_next = S_IDLE;
              end else begin
                cmd.setup  = 1'b1;
                state_next = stat.need_shift ? S_SHIFT : S_FINAL;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        cmd.latch  = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.latch  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/ols_datapath.sv
// ----------------------------------------------------------------------------
// ols_datapath
// Entry memory, count and reserved size registers, shift pointers, result.
// ----------------------------------------------------------------------------
module ols_datapath #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ols_pkg::ols_in_t   req,
  input  ols_pkg::ols_cmd_t  cmd,
  output ols_pkg::ols_stat_t stat,
  output logic               done,
  output ols_pkg::ols_out_t  rsp
);
  import ols_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE   = (CNT_W > 7) ? CNT_W : 7;

  logic signed [31:0] mem [DEPTH];
  op_t                op;
  logic [WIDE-1:0]    pos_w;
  logic signed [31:0] val;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cap;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [ADDR_W-1:0]  wr_ptr;
  logic               pend;
  logic signed [31:0] rdata;

  logic               is_ins;
  logic [WIDE-1:0]    cnt_w;
  logic [WIDE-1:0]    rd_ptr_w;
  logic [CNT_W:0]     cap_dbl;
  logic [CNT_W-1:0]   cap_next;
  logic [CNT_W-1:0]   cnt_after;
  logic [WIDE-1:0]    cnt_after_w;
  logic [WIDE-1:0]    cap_w;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  assign is_ins   = (op == OP_APPEND) || (op == OP_INSERT);
  assign cnt_w    = WIDE'(cnt);
  assign rd_ptr_w = WIDE'(rd_ptr);
  assign cap_dbl  = {cap, 1'b0};

  always_comb begin
    if (cap == '0) begin
      cap_next = CNT_W'(2);
    end else if (cap_dbl > (CNT_W + 1)'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = cap_dbl[CNT_W-1:0];
    end
  end

  always_comb begin
    if (cmd.finish) begin
      cnt_after = is_ins ? cnt + CNT_W'(1) : cnt - CNT_W'(1);
    end else begin
      cnt_after = cnt;
    end
  end

  assign cnt_after_w = WIDE'(cnt_after);
  assign cap_w       = WIDE'(cap);

  assign stat.op         = op;
  assign stat.bad        = is_ins ? (pos_w > cnt_w) : (pos_w >= cnt_w);
  assign stat.full       = (cnt_w == WIDE'(DEPTH));
  assign stat.need_shift = is_ins ? (pos_w < cnt_w) : ((pos_w + WIDE'(1)) < cnt_w);
  assign stat.last       = is_ins ? (rd_ptr_w == pos_w) : (rd_ptr_w == cnt_w - WIDE'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req.command;
      pos_w <= (req.command == OP_APPEND) ? cnt_w : WIDE'(req.position);
      val   <= req.value;
    end
    if (cmd.setup) begin
      rd_ptr <= is_ins ? ADDR_W'(cnt - CNT_W'(1)) : ADDR_W'(pos_w + WIDE'(1));
    end else if (cmd.step) begin
      rd_ptr <= is_ins ? rd_ptr - ADDR_W'(1) : rd_ptr + ADDR_W'(1);
    end
    if (cmd.step) begin
      wr_ptr <= is_ins ? rd_ptr + ADDR_W'(1) : rd_ptr - ADDR_W'(1);
    end
    if (cmd.latch) begin
      rsp.read_value    <= (cmd.status == ST_DONE && op == OP_READ) ? rdata : '0;
      rsp.status        <= cmd.status;
      rsp.element_count <= cnt_after_w[6:0];
      rsp.capacity      <= cap_w[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      cap  <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= cmd.step;
      done <= cmd.latch;
      cnt  <= cnt_after;
      if (cmd.setup && is_ins && (cnt >= cap)) begin
        cap <= cap_next;
      end
    end
  end

  assign rd_en   = cmd.step || cmd.rd_issue;
  assign rd_addr = cmd.step ? rd_ptr : pos_w[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      mem[wr_ptr] <= rdata;
    end else if (cmd.finish && is_ins) begin
      mem[pos_w[ADDR_W-1:0]] <= val;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_cap_covers: assert property (@(posedge clk) disable iff (rst)
    (cap >= cnt) && (cap <= CNT_W'(DEPTH)))
    else $error("reserved size out of range");

  a_wr_conflict: assert property (@(posedge clk) disable iff (rst)
    !(pend && cmd.finish))
    else $error("shift write collides with final write");

  a_step_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> pend)
    else $error("shift read not followed by write");

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_DONE || rsp.status == ST_BADPOS || rsp.status == ST_FULL))
    else $error("result carries an unknown status");

endmodule

FILE: src/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered store of signed 32-bit words with append, insert, erase and read.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// busy stays high until the result has been formed; the result is presented
// on result with done high for exactly one cycle and cannot be held off, so
// the receiver must take it in that cycle. A new request may be issued in the
// same cycle that done is high.
// An error is reported straight from the check state; a read, or an insert,
// append or erase that moves no entries, passes through the read or final
// state; when entries move, the request runs through the shift, drain and
// final states. Entries move one per cycle through the single read and single
// write port of the entry memory.
// Reset clears the entry count and the reserved size; the entry memory is not
// cleared and holds no data until written.
// Every result reports the count and reserved size after the request,
// truncated to 7 bits.
// ----------------------------------------------------------------------------
module ordered_list_store #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ols_pkg::ols_in_t  request,
  output logic              done,
  output ols_pkg::ols_out_t result
);
  import ols_pkg::*;

  ols_cmd_t  cmd;
  ols_stat_t stat;

  ols_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  ols_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (request),
    .cmd  (cmd),
    .stat (stat),
    .done (done),
    .rsp  (result)
  );

endmodule

FILE: tb/ols_checker.sv
// ----------------------------------------------------------------------------
// ols_checker
// Watches the request and result channels of the ordered list store, keeps
// its own copy of the entries, count and reserved size, works out the
// result of every accepted request and compares each result, field by field,
// with the oldest result still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ols_checker #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  ols_pkg::ols_in_t  request,
  input  logic              done,
  input  ols_pkg::ols_out_t result,
  output int                errors,
  output int                pending
);
  import ols_pkg::*;

  localparam int PRINT_LIMIT = 50;

  logic signed [31:0] words [DEPTH];
  int                 fill;
  int                 reserved;
  int                 fail_count;
  ols_out_t           outstanding_results[$];

  task automatic report(string what, longint want, longint got);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t ns mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    end
    fail_count++;
  endtask

  function automatic ols_out_t apply_request(ols_in_t r);
    ols_out_t o;
    int       at;
    o = '0;
    o.status = ST_DONE;
    at = int'(r.position);
    case (r.command)
      OP_APPEND, OP_INSERT: begin
        if (r.command == OP_APPEND) at = fill;
        if (at > fill) begin
          o.status = ST_BADPOS;
        end else if (fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          if (fill >= reserved) begin
            reserved = (reserved == 0) ? 2 : reserved * 2;
            if (reserved > DEPTH) reserved = DEPTH;
          end
          for (int i = fill; i > at; i--) words[i] = words[i - 1];
          words[at] = r.value;
          fill++;
        end
      end
      OP_ERASE: begin
        if (at >= fill) begin
          o.status = ST_BADPOS;
        end else begin
          for (int i = at; i + 1 < fill; i++) words[i] = words[i + 1];
          fill--;
        end
      end
      default: begin
        if (at >= fill) begin
          o.status = ST_BADPOS;
        end else begin
          o.read_value = words[at];
        end
      end
    endcase
    o.element_count = 7'(fill);
    o.capacity = 7'(reserved);
    return o;
  endfunction

  always @(posedge clk) begin
    ols_out_t want;
    if (rst) begin
      fill = 0;
      reserved = 0;
      outstanding_results.delete();
    end else begin
      if (done) begin
        if (outstanding_results.size() == 0) begin
          report("result with no request outstanding", 0, 1);
        end else begin
          want = outstanding_results.pop_front();
          if (result.read_value !== want.read_value)
            report("read_value", want.read_value, result.read_value);
          if (result.status !== want.status)
            report("status", want.status, result.status);
          if (result.element_count !== want.element_count)
            report("element_count", want.element_count, result.element_count);
          if (result.capacity !== want.capacity)
            report("capacity", want.capacity, result.capacity);
        end
      end
      if (start && !busy)
        outstanding_results.insert(outstanding_results.size(), apply_request(request));
    end
    errors <= fail_count;
    pending <= outstanding_results.size();
  end

endmodule

FILE: tb/tb_ordered_list_store.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_store
// Drives the ordered list store with a short directed sequence and then with
// random requests that fill the store to its limit and drain it again, over
// three phases of sender idling; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_store;
  import ols_pkg::*;

  localparam int DEPTH = 64;
  localparam int ITEMS = 1900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  ols_in_t  request;
  ols_out_t result;
  int       errors;
  int       pending;
  int       level;
  int       idle_pct;
  int       full_hits;
  int       sent;
  int       stall_cycles;
  logic     shrinking;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ordered_list_store #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  ols_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .errors(errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic ols_in_t make_request(op_t command, int position, logic [31:0] value);
    ols_in_t r;
    r.command = command;
    r.position = 7'(position);
    r.value = value;
    return r;
  endfunction

  function automatic ols_in_t random_request();
    ols_in_t r;
    int      roll;
    int      span;
    roll = $urandom_range(99);
    if (!shrinking) begin
      r.command = (roll < 40) ? OP_APPEND : (roll < 75) ? OP_INSERT :
                  (roll < 90) ? OP_READ : OP_ERASE;
    end else begin
      r.command = (roll < 15) ? OP_APPEND : (roll < 25) ? OP_INSERT :
                  (roll < 45) ? OP_READ : OP_ERASE;
    end
    span = (r.command == OP_INSERT) ? level : level - 1;
    roll = $urandom_range(99);
    if (roll < 10 || span < 0) r.position = 7'($urandom_range(127));
    else if (roll < 20) r.position = 7'(span);
    else if (roll < 28) r.position = '0;
    else r.position = 7'($urandom_range(span));
    roll = $urandom_range(99);
    r.value = (roll < 5) ? 32'h8000_0000 : (roll < 10) ? 32'h7fff_ffff : $urandom();
    return r;
  endfunction

  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send(ols_in_t r);
    logic grows;
    idle_gap();
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    grows = (r.command == OP_APPEND) || (r.command == OP_INSERT && int'(r.position) <= level);
    if (grows && level == DEPTH) begin
      full_hits++;
      if (full_hits >= 3) begin
        shrinking = 1'b1;
        full_hits = 0;
      end
    end else if (grows) begin
      level++;
    end else if (r.command == OP_ERASE && int'(r.position) < level) begin
      level--;
      if (level == 0) shrinking = 1'b0;
    end
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic directed();
    send(make_request(OP_READ, 0, 0));
    send(make_request(OP_ERASE, 0, 0));
    send(make_request(OP_INSERT, 1, 32'h1111_1111));
    send(make_request(OP_INSERT, 0, 32'h7fff_ffff));
    send(make_request(OP_APPEND, 127, 32'h8000_0000));
    send(make_request(OP_APPEND, 0, 32'hffff_ffff));
    send(make_request(OP_APPEND, 0, 32'h0000_0000));
    send(make_request(OP_INSERT, 2, 32'h5a5a_5a5a));
    send(make_request(OP_INSERT, 5, 32'h1234_5678));
    send(make_request(OP_INSERT, 7, 32'h2222_2222));
    send(make_request(OP_READ, 0, 0));
    send(make_request(OP_READ, 2, 0));
    send(make_request(OP_READ, 5, 0));
    send(make_request(OP_READ, 6, 0));
    send(make_request(OP_READ, 64, 0));
    send(make_request(OP_READ, 127, 32'hffff_ffff));
    send(make_request(OP_ERASE, 0, 0));
    send(make_request(OP_ERASE, 4, 0));
    send(make_request(OP_ERASE, 1, 0));
    send(make_request(OP_ERASE, 64, 0));
    send(make_request(OP_READ, 0, 0));
    send(make_request(OP_READ, 2, 0));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    level = 0;
    full_hits = 0;
    sent = 0;
    shrinking = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 22 : (phase == 1) ? 48 : 0;
      if (phase == 0) directed();
      while (sent < (phase + 1) * ITEMS / 3) send(random_request());
      pause_until_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ols_pkg.sv
src/ols_ctrl.sv
src/ols_datapath.sv
src/ordered_list_store.sv
tb/ols_checker.sv
tb/tb_ordered_list_store.sv
